// ===== rtl/kst_pkg.sv =====
// shared types and constants of the keyed slot table
`default_nettype none
package kst_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int KEY_IN_W = 32;
	localparam int SIZE_W   = 16;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ENTRY_W  = KEY_BITS + SIZE_W;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// set or clear one occupancy flag
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [SLOT_W-1:0] idx;
	} flag_op_t;

	// one write port and one read port of the entry memory
	typedef struct packed {
		logic               we;
		logic [SLOT_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [SLOT_W-1:0]  raddr;
	} ram_req_t;

endpackage
`default_nettype wire

// ===== rtl/kst_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/kst_flags.sv =====
// occupancy flags of the slot table, cleared at reset
`default_nettype none
module kst_flags import kst_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire flag_op_t          flag_op,
	input  wire logic [SLOT_W-1:0] rd_idx,
	output logic                   rd_flag
);

	logic [CAPACITY-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (flag_op.set) begin
				valid_q[flag_op.idx] <= 1'b1;
			end
			if (flag_op.clr) begin
				valid_q[flag_op.idx] <= 1'b0;
			end
		end
	end

	assign rd_flag = valid_q[rd_idx];

endmodule
`default_nettype wire

// ===== rtl/kst_seq.sv =====
// command sequencer: add, slot scans and result registers
`default_nettype none
module kst_seq import kst_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          cmd,
	input  wire logic [KEY_IN_W-1:0] key,
	input  wire logic [SIZE_W-1:0]   dom_value,
	output logic                     busy,
	output logic                     done,
	output logic [1:0]               status,
	output logic                     found,
	output logic [SIZE_W-1:0]        size_out,
	output logic [SLOT_W-1:0]        slot_out,
	output logic [CNT_W-1:0]         entry_count,
	output logic [SLOT_W-1:0]        flag_rd_idx,
	input  wire logic                flag_rd,
	output flag_op_t                 flag_op,
	output ram_req_t                 ram_req,
	input  wire logic [ENTRY_W-1:0]  ram_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FREE,
		S_SCAN
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);

	state_t              state_q;
	logic                is_remove_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SLOT_W-1:0]   free_ptr_q;
	logic                full_q;
	logic [SLOT_W-1:0]   hit_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [CNT_W-1:0]    issued_q;
	logic                rd_vld_s1;
	logic [SLOT_W-1:0]   rd_idx_s1;
	logic                flag_s1;

	logic                done_q;
	status_t             status_q;
	logic                found_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    cnt_out_q;

	logic                add_go;
	logic                match;
	logic [SLOT_W-1:0]   idx_next;
	logic [KEY_BITS-1:0] key_in;

	assign key_in   = KEY_BITS'(key);
	assign idx_next = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
	assign add_go   = (state_q == S_IDLE) && start && (cmd == CMD_ADD) && !full_q;
	assign match    = (state_q == S_SCAN) && rd_vld_s1 && flag_s1
		&& (ram_rdata[KEY_BITS-1:0] == key_q);

	always_comb begin
		flag_op.set   = add_go;
		flag_op.clr   = match && is_remove_q;
		flag_op.idx   = add_go ? free_ptr_q : rd_idx_s1;
		ram_req.we    = add_go;
		ram_req.waddr = free_ptr_q;
		ram_req.wdata = {dom_value, key_in};
		ram_req.raddr = idx_q;
	end

	assign flag_rd_idx = idx_q;
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign size_out    = size_q;
	assign slot_out    = slot_q;
	assign entry_count = cnt_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			is_remove_q <= 1'b0;
			key_q       <= '0;
			free_ptr_q  <= '0;
			full_q      <= 1'b0;
			hit_ptr_q   <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			issued_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			flag_s1     <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			found_q     <= 1'b0;
			size_q      <= '0;
			slot_q      <= '0;
			cnt_out_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						is_remove_q <= (cmd == CMD_REMOVE);
						key_q       <= key_in;
						done_q      <= 1'b0;
						found_q     <= 1'b0;
						size_q      <= '0;
						slot_q      <= '0;
						status_q    <= ST_OK;
						cnt_out_q   <= count_q;
						unique case (cmd_t'(cmd))
							CMD_ADD: begin
								done_q <= 1'b1;
								if (full_q) begin
									status_q <= ST_FULL;
								end else begin
									count_q   <= count_q + 1'b1;
									cnt_out_q <= count_q + 1'b1;
									slot_q    <= free_ptr_q;
									if (free_ptr_q == LAST_SLOT) begin
										full_q <= 1'b1;
									end else begin
										idx_q   <= free_ptr_q + 1'b1;
										state_q <= S_FREE;
									end
								end
							end
							CMD_LOOKUP, CMD_REMOVE: begin
								idx_q     <= hit_ptr_q;
								issued_q  <= '0;
								rd_vld_s1 <= 1'b0;
								state_q   <= S_SCAN;
							end
							CMD_NOP: begin
								done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_FREE: begin
					if (!flag_rd) begin
						free_ptr_q <= idx_q;
						full_q     <= 1'b0;
						state_q    <= S_IDLE;
					end else if (idx_q == LAST_SLOT) begin
						full_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN: begin
					// issue one read a cycle, check it the cycle after
					if (issued_q != CAP_CNT) begin
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= idx_q;
						flag_s1   <= flag_rd;
						idx_q     <= idx_next;
						issued_q  <= issued_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (match) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						found_q   <= 1'b1;
						slot_q    <= rd_idx_s1;
						hit_ptr_q <= rd_idx_s1;
						if (is_remove_q) begin
							size_q <= '0;
							if (count_q != '0) begin
								count_q   <= count_q - 1'b1;
								cnt_out_q <= count_q - 1'b1;
							end else begin
								cnt_out_q <= count_q;
							end
							if (full_q || (free_ptr_q > rd_idx_s1)) begin
								free_ptr_q <= rd_idx_s1;
							end
							full_q <= 1'b0;
						end else begin
							size_q    <= ram_rdata[KEY_BITS +: SIZE_W];
							cnt_out_q <= count_q;
						end
					end else if (issued_q == CAP_CNT) begin
						// last slot checked with no match
						rd_vld_s1 <= 1'b0;
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
						status_q  <= ST_MISS;
						found_q   <= 1'b0;
						size_q    <= '0;
						slot_q    <= '0;
						cnt_out_q <= count_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/keyed_slot_table_top.sv =====
// top level of the keyed slot table
`default_nettype none
// keyed slot table: 64 entries of key and 16-bit domain size with occupancy flags
//
// command channel: a transfer happens at a rising edge with start high and busy
// low; cmd selects add, lookup, remove or no-op, key and dom_value come with it
// result channel: done pulses for one cycle with status, found, size_out,
// slot_out and entry_count; the receiver cannot stall, every result is taken
//
// sequence of each command after the accepting edge:
//   add and no-op: result in the next cycle; after an add to any slot but
//   the last, busy stays high while the flags above the written slot are
//   walked one per cycle for the next free slot
//   lookup and remove: circular walk from the last hit slot, one entry read
//   per cycle through the registered read port of the entry memory; the result
//   comes on the first match, or as a miss once all 64 slots are checked
// only one command is in flight, so no read that meets a memory write of the
// same entry has its data used
// reset: all occupancy flags, pointers and the entry count clear at once; the
// entry memory is left as is, an entry is only matched once its flag is set
module keyed_slot_table_top import kst_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          cmd,
	input  wire logic [KEY_IN_W-1:0] key,
	input  wire logic [SIZE_W-1:0]   dom_value,
	output logic                     done,
	output logic [1:0]               status,
	output logic                     found,
	output logic [SIZE_W-1:0]        size_out,
	output logic [SLOT_W-1:0]        slot_out,
	output logic [CNT_W-1:0]         entry_count
);

	// sequencer to flag store and entry memory
	flag_op_t           flag_op;
	ram_req_t           ram_req;
	logic [SLOT_W-1:0]  flag_rd_idx;
	logic               flag_rd;
	logic [ENTRY_W-1:0] ram_rdata;

	// command sequencing, pointers and result registers
	kst_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.key         (key),
		.dom_value   (dom_value),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.found       (found),
		.size_out    (size_out),
		.slot_out    (slot_out),
		.entry_count (entry_count),
		.flag_rd_idx (flag_rd_idx),
		.flag_rd     (flag_rd),
		.flag_op     (flag_op),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

	// occupancy flags in flops so reset empties the table at once
	kst_flags u_flags (
		.clk     (clk),
		.arst_n  (arst_n),
		.flag_op (flag_op),
		.rd_idx  (flag_rd_idx),
		.rd_flag (flag_rd)
	);

	// key and domain size per slot, {size, key}
	kst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// a hit always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK)
		else $error("found result with non-ok status");

	// a refused add only happens with every slot taken
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
		else $error("full status with free slots");

	// a miss carries no slot and no size
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_MISS |-> slot_out == '0 && size_out == '0 && !found)
		else $error("miss result carries data");

	// a lookup always walks the memory before answering
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_LOOKUP |=> busy && !done)
		else $error("lookup answered without a scan");
`endif

endmodule
`default_nettype wire

// ===== bench/keyed_slot_table_top_tb.sv =====
// self-checking testbench of the keyed slot table: directed and random command streams
`timescale 1ns / 100ps
module keyed_slot_table_top_tb import kst_pkg::*;;

	// cycles with no transfer and no result before the run is declared hung
	localparam int STALL_LIMIT  = 2000;
	// longest walk of a lookup or remove miss plus margin
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1630;
	// the tail of the random part runs with no idling at all
	localparam int CALM_TAIL    = 200;

	// one expected result of the table
	typedef struct packed {
		status_t           status;
		logic              found;
		logic [SIZE_W-1:0] size;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
	} table_reply_t;

	// mix of commands in one stretch of the random part
	typedef enum logic [1:0] {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	// predicted table contents plus the queue of replies still owed by the block
	class slot_table_scoreboard;
		bit                  occupied[CAPACITY];
		logic [KEY_BITS-1:0] keys[CAPACITY];
		logic [SIZE_W-1:0]   sizes[CAPACITY];
		int unsigned         next_free;
		bit                  is_full;
		int unsigned         last_hit;
		int unsigned         live;
		table_reply_t        owed[$];
		int unsigned         errors;

		function new();
			foreach (occupied[i]) begin
				occupied[i] = 1'b0;
				keys[i] = '0;
				sizes[i] = '0;
			end
			next_free = 0;
			is_full = 1'b0;
			last_hit = 0;
			live = 0;
			errors = 0;
		endfunction

		// circular walk from the last hit slot, first valid match wins
		function bit find_key(logic [KEY_BITS-1:0] k, output int unsigned slot);
			int unsigned s;
			s = last_hit % CAPACITY;
			slot = 0;
			for (int n = 0; n < CAPACITY; n++) begin
				if (occupied[s] && keys[s] == k) begin
					slot = s;
					return 1'b1;
				end
				s = (s + 1 == CAPACITY) ? 0 : s + 1;
			end
			return 1'b0;
		endfunction

		// apply one accepted command and queue the reply it must produce
		function void note_cmd(cmd_t c, logic [KEY_IN_W-1:0] k, logic [SIZE_W-1:0] dv);
			table_reply_t        r;
			logic [KEY_BITS-1:0] kk;
			int unsigned         s;
			kk = k;
			r = '0;
			r.status = ST_OK;
			case (c)
				CMD_ADD: begin
					if (is_full) begin
						r.status = ST_FULL;
					end else begin
						s = next_free % CAPACITY;
						occupied[s] = 1'b1;
						keys[s] = kk;
						sizes[s] = dv;
						live++;
						r.slot = SLOT_W'(s);
						is_full = 1'b1;
						for (int i = s + 1; i < CAPACITY; i++) begin
							if (!occupied[i]) begin
								next_free = i;
								is_full = 1'b0;
								break;
							end
						end
					end
				end
				CMD_LOOKUP: begin
					if (find_key(kk, s)) begin
						last_hit = s;
						r.found = 1'b1;
						r.size = sizes[s];
						r.slot = SLOT_W'(s);
					end else begin
						r.status = ST_MISS;
					end
				end
				CMD_REMOVE: begin
					if (find_key(kk, s)) begin
						occupied[s] = 1'b0;
						if (live > 0)
							live--;
						// freed slot below the free pointer, or any slot while full
						if (is_full || next_free > s)
							next_free = s;
						is_full = 1'b0;
						last_hit = s;
						r.found = 1'b1;
						r.slot = SLOT_W'(s);
					end else begin
						r.status = ST_MISS;
					end
				end
				default: begin
				end
			endcase
			r.count = CNT_W'(live);
			owed.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			end
		endfunction

		// compare one reply with the oldest owed one
		function void check_result(logic [1:0] st, logic f, logic [SIZE_W-1:0] sz,
				logic [SLOT_W-1:0] sl, logic [CNT_W-1:0] cnt);
			table_reply_t e;
			if (owed.size() == 0) begin
				errors++;
				$error("result with nothing outstanding: status %0h slot %0h", st, sl);
				return;
			end
			e = owed.pop_front();
			compare_field("status", e.status, st);
			compare_field("found", e.found, f);
			compare_field("size_out", e.size, sz);
			compare_field("slot_out", e.slot, sl);
			compare_field("entry_count", e.count, cnt);
		endfunction

		// key of some valid entry, or a fresh random key when the table is empty
		function logic [KEY_IN_W-1:0] live_key();
			int unsigned idx[$];
			foreach (occupied[i])
				if (occupied[i])
					idx.push_back(i);
			if (idx.size() == 0)
				return $urandom;
			return keys[idx[$urandom_range(0, idx.size() - 1)]];
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          cmd = CMD_NOP;
	logic [KEY_IN_W-1:0] key = '0;
	logic [SIZE_W-1:0]   dom_value = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic                found;
	logic [SIZE_W-1:0]   size_out;
	logic [SLOT_W-1:0]   slot_out;
	logic [CNT_W-1:0]    entry_count;

	slot_table_scoreboard sb = new();
	int unsigned          quiet_cycles = 0;

	keyed_slot_table_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.key         (key),
		.dom_value   (dom_value),
		.done        (done),
		.status      (status),
		.found       (found),
		.size_out    (size_out),
		.slot_out    (slot_out),
		.entry_count (entry_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// result side: the block cannot be stalled, every strobe is one reply
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, found, size_out, slot_out, entry_count);
	end

	// watchdog: any transfer or reply restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[keyed_slot_table_top] ERROR");
				$finish;
			end
		end
	end

	// hold the command on the ports until a transfer happens, then predict it
	task automatic issue(input cmd_t c, input logic [KEY_IN_W-1:0] k,
			input logic [SIZE_W-1:0] dv);
		start <= 1'b1;
		cmd <= c;
		key <= k;
		dom_value <= dv;
		do
			@(posedge clk);
		while (busy);
		sb.note_cmd(c, k, dv);
	endtask

	// sender idle burst
	task automatic pause(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		phase_t              phase;
		int unsigned         phase_end;
		int unsigned         roll;
		bit                  idling;
		cmd_t                c;
		logic [KEY_IN_W-1:0] k;
		logic [SIZE_W-1:0]   dv;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// misses and no-ops on an empty table, extreme field values
		issue(CMD_LOOKUP, 32'h0000_0000, 16'hffff);
		issue(CMD_REMOVE, 32'hffff_ffff, 16'h0000);
		issue(CMD_NOP, 32'hffff_ffff, 16'hffff);
		issue(CMD_NOP, 32'h0000_0000, 16'h0000);
		// fill slots 0..3, with a duplicate key in slot 3
		issue(CMD_ADD, 32'h0000_0000, 16'h0000);
		issue(CMD_ADD, 32'hffff_ffff, 16'hffff);
		issue(CMD_ADD, 32'h1234_5678, 16'h8000);
		issue(CMD_ADD, 32'h0000_0000, 16'h1234);
		// hit moves the walk start to slot 1, so the duplicate in slot 3 wins next
		issue(CMD_LOOKUP, 32'hffff_ffff, 16'h0000);
		issue(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
		// freed slots below the free pointer pull it down
		issue(CMD_REMOVE, 32'h0000_0000, 16'hffff);
		issue(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
		issue(CMD_REMOVE, 32'h1234_5678, 16'h0000);
		issue(CMD_ADD, 32'ha5a5_a5a5, 16'h0001);
		issue(CMD_ADD, 32'h5a5a_5a5a, 16'hfffe);
		// misses with entries present
		issue(CMD_LOOKUP, 32'hdead_beef, 16'h0000);
		issue(CMD_REMOVE, 32'hdead_beef, 16'h0000);
		// back to empty
		issue(CMD_REMOVE, 32'hffff_ffff, 16'h0000);
		issue(CMD_REMOVE, 32'h0000_0000, 16'h0000);
		issue(CMD_REMOVE, 32'ha5a5_a5a5, 16'h0000);
		issue(CMD_REMOVE, 32'h5a5a_5a5a, 16'h0000);
		issue(CMD_LOOKUP, 32'ha5a5_a5a5, 16'h0000);

		// random part in stretches: fill to full and past it, drain, mixed
		phase = PH_FILL;
		phase_end = $urandom_range(90, 150);
		idling = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == phase_end) begin
				phase = phase_t'($urandom_range(0, 2));
				phase_end = n + $urandom_range(60, 140);
				// some stretches run back to back
				idling = ($urandom_range(0, 2) != 0);
			end
			roll = $urandom_range(0, 99);
			case (phase)
				PH_FILL:  c = (roll < 80) ? CMD_ADD : (roll < 90) ? CMD_LOOKUP :
						(roll < 97) ? CMD_REMOVE : CMD_NOP;
				PH_DRAIN: c = (roll < 15) ? CMD_ADD : (roll < 35) ? CMD_LOOKUP :
						(roll < 97) ? CMD_REMOVE : CMD_NOP;
				default:  c = (roll < 40) ? CMD_ADD : (roll < 65) ? CMD_LOOKUP :
						(roll < 95) ? CMD_REMOVE : CMD_NOP;
			endcase
			roll = $urandom_range(0, 99);
			// lookups and removes mostly hit; adds sometimes repeat a live key
			if (c == CMD_LOOKUP || c == CMD_REMOVE)
				k = (roll < 80) ? sb.live_key() : $urandom;
			else if (c == CMD_ADD && roll < 10)
				k = sb.live_key();
			else
				k = $urandom;
			roll = $urandom_range(0, 19);
			dv = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hffff :
				SIZE_W'($urandom_range(0, 65535));
			issue(c, k, dv);
			if (idling && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
				pause($urandom_range(1, 18));
		end
		start <= 1'b0;

		// wait for every owed reply, then let the block settle
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("[keyed_slot_table_top] OK");
		else
			$display("[keyed_slot_table_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/kst_pkg.sv
rtl/kst_ram.sv
rtl/kst_flags.sv
rtl/kst_seq.sv
rtl/keyed_slot_table_top.sv
bench/keyed_slot_table_top_tb.sv
